/* design/dlt_pkg.sv */
`default_nettype none

package dlt_pkg;

    // Message kinds as they arrive from the parser
    localparam logic [2:0] KIND_DISCOVER = 3'd0;
    localparam logic [2:0] KIND_REQUEST  = 3'd1;
    localparam logic [2:0] KIND_RELEASE  = 3'd2;
    localparam logic [2:0] KIND_DECLINE  = 3'd3;
    localparam logic [2:0] KIND_INFORM   = 3'd4;
    localparam logic [2:0] KIND_LOAD     = 3'd5;

    // Reply codes
    localparam logic [1:0] REPLY_OFFER = 2'd0;
    localparam logic [1:0] REPLY_ACK   = 2'd1;
    localparam logic [1:0] REPLY_NAK   = 2'd2;

    // Configuration register indexes
    localparam int         CFG_INDEX_W        = 1;
    localparam logic [0:0] REG_SERVER_ADDRESS = 1'd0;
    localparam logic [0:0] REG_ENTRY_COUNT    = 1'd1;

    localparam int         CFG_DATA_W        = 32;
    localparam logic [3:0] ENTRY_COUNT_RESET = 4'd8;

    // Fixed field widths
    localparam int KIND_W  = 3;
    localparam int LEN_W   = 3;
    localparam int IP_W    = 32;
    localparam int LIDX_W  = 3;
    localparam int RKIND_W = 2;
    localparam int GENT_W  = 3;
    localparam int CNT_REG_W = 4;

    // Commands handed from the front to the back
    typedef enum logic [1:0] {
        OP_DISCOVER,
        OP_REQUEST,
        OP_RELEASE,
        OP_LOAD
    } op_t;

    typedef struct packed {
        op_t  op;
        logic has_req;
    } cmd_ctl_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DECIDE,
        BK_CLAIM_RD,
        BK_CLAIM_WR
    } bk_state_t;

endpackage

`default_nettype wire

/* design/dlt_if.sv */
`default_nettype none

// Client message channel
interface dlt_req_if #(
    parameter int MAC_BYTES = 6
);
    logic                           valid;
    logic                           ready;
    logic [dlt_pkg::KIND_W-1:0]     kind;
    logic [8*MAC_BYTES-1:0]         client_mac;
    logic [dlt_pkg::LEN_W-1:0]      mac_len;
    logic                           has_requested_ip;
    logic [dlt_pkg::IP_W-1:0]       requested_ip;
    logic                           has_server_id;
    logic [dlt_pkg::IP_W-1:0]       server_id;
    logic [dlt_pkg::LIDX_W-1:0]     load_index;
    logic [dlt_pkg::IP_W-1:0]       load_address;

    modport source (
        output valid, kind, client_mac, mac_len, has_requested_ip, requested_ip,
               has_server_id, server_id, load_index, load_address,
        input  ready
    );
    modport sink (
        input  valid, kind, client_mac, mac_len, has_requested_ip, requested_ip,
               has_server_id, server_id, load_index, load_address,
        output ready
    );
endinterface

// Reply channel
interface dlt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [dlt_pkg::RKIND_W-1:0]    reply_kind;
    logic [dlt_pkg::IP_W-1:0]       granted_address;
    logic [dlt_pkg::GENT_W-1:0]     granted_entry;

    modport source (
        output valid, reply_kind, granted_address, granted_entry,
        input  ready
    );
    modport sink (
        input  valid, reply_kind, granted_address, granted_entry,
        output ready
    );
endinterface

// Configuration write channel
interface dlt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dlt_pkg::CFG_INDEX_W-1:0]    index;
    logic [dlt_pkg::CFG_DATA_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

/* design/dlt_ram.sv */
`default_nettype none

module dlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic [AW-1:0]         raddr,
    output logic      [WIDTH-1:0]      rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/dlt_fifo.sv */
`default_nettype none

module dlt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [WIDTH-1:0]       pop_data,
    output logic                   not_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* design/dlt_front.sv */
`default_nettype none

module dlt_front #(
    parameter int TABLE_DEPTH = 8,
    parameter int MAC_BYTES   = 6
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    dlt_req_if.sink             req_ch,
    dlt_cfg_if.sink             cfg_ch,
    output logic                push,
    output logic [CMD_W-1:0]    push_data,
    input  wire logic           full
);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MW    = 8 * MAC_BYTES;
    localparam int CMD_W = $bits(dlt_pkg::cmd_ctl_t) + CNT_W + MW + MAC_BYTES
                           + dlt_pkg::IP_W + dlt_pkg::LIDX_W;

    logic [dlt_pkg::IP_W-1:0]      server_address_reg;
    logic [dlt_pkg::CNT_REG_W-1:0] entry_count_reg;

    dlt_pkg::cmd_ctl_t          ctl;
    logic                       keep;
    logic                       sid_ok;
    logic [CNT_W-1:0]           scan_count;
    logic [MAC_BYTES-1:0]       byte_en;
    logic [dlt_pkg::IP_W-1:0]   addr_field;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_address_reg <= '0;
            entry_count_reg    <= dlt_pkg::ENTRY_COUNT_RESET;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                dlt_pkg::REG_SERVER_ADDRESS: server_address_reg <= cfg_ch.data;
                dlt_pkg::REG_ENTRY_COUNT:
                    entry_count_reg <= cfg_ch.data[dlt_pkg::CNT_REG_W-1:0];
            endcase
        end
    end

    // Saturate the entry count at the table depth
    assign scan_count = (32'(entry_count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                              : CNT_W'(entry_count_reg);

    assign sid_ok = !req_ch.has_server_id || (req_ch.server_id == server_address_reg);

    // Byte b sits at bits [8b+7:8b]; enable the leading mac_len bytes
    always_comb
    begin
        for (int b = 0; b < MAC_BYTES; b++)
        begin
            byte_en[b] = ((MAC_BYTES - 1 - b) < int'(req_ch.mac_len));
        end
    end

    always_comb
    begin
        ctl.op      = dlt_pkg::OP_DISCOVER;
        ctl.has_req = req_ch.has_requested_ip;
        keep        = 1'b0;
        unique case (req_ch.kind) inside
            dlt_pkg::KIND_DISCOVER:
            begin
                ctl.op = dlt_pkg::OP_DISCOVER;
                keep   = 1'b1;
            end
            dlt_pkg::KIND_REQUEST:
            begin
                ctl.op = dlt_pkg::OP_REQUEST;
                keep   = sid_ok;
            end
            dlt_pkg::KIND_RELEASE:
            begin
                ctl.op = dlt_pkg::OP_RELEASE;
                keep   = sid_ok;
            end
            dlt_pkg::KIND_DECLINE, dlt_pkg::KIND_INFORM:
            begin
                keep = 1'b0;
            end
            dlt_pkg::KIND_LOAD:
            begin
                ctl.op = dlt_pkg::OP_LOAD;
                keep   = (32'(req_ch.load_index) < TABLE_DEPTH);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign addr_field = (ctl.op == dlt_pkg::OP_LOAD) ? req_ch.load_address
                                                     : req_ch.requested_ip;

    // Drop ignored messages here; they are accepted and never reach the back
    assign req_ch.ready = !full;
    assign push         = req_ch.valid && !full && keep;
    assign push_data    = {ctl, scan_count, req_ch.client_mac, byte_en, addr_field,
                           req_ch.load_index};

endmodule

`default_nettype wire

/* design/dlt_back.sv */
`default_nettype none

module dlt_back #(
    parameter int TABLE_DEPTH = 8,
    parameter int MAC_BYTES   = 6
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire logic [CMD_W-1:0] cmd_data,
    output logic                cmd_pop,
    dlt_rsp_if.source           rsp_ch
);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MW    = 8 * MAC_BYTES;
    localparam int IPW   = dlt_pkg::IP_W;
    localparam int CMD_W = $bits(dlt_pkg::cmd_ctl_t) + CNT_W + MW + MAC_BYTES
                           + IPW + dlt_pkg::LIDX_W;

    // Unpacked command head
    dlt_pkg::cmd_ctl_t          c_ctl;
    logic [CNT_W-1:0]           c_cnt;
    logic [MW-1:0]              c_mac;
    logic [MAC_BYTES-1:0]       c_be;
    logic [IPW-1:0]             c_addr;
    logic [dlt_pkg::LIDX_W-1:0] c_lidx;
    logic [MW-1:0]              c_mask;

    assign {c_ctl, c_cnt, c_mac, c_be, c_addr, c_lidx} = cmd_data;

    always_comb
    begin
        for (int b = 0; b < MAC_BYTES; b++)
        begin
            c_mask[8*b +: 8] = {8{c_be[b]}};
        end
    end

    // Control state
    dlt_pkg::bk_state_t     state_reg, state_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] alloc_reg, alloc_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic                   own_found_reg, own_found_next;
    logic                   addr_found_reg, addr_found_next;
    logic                   spare_found_reg, spare_found_next;
    logic                   spare_lock_reg, spare_lock_next;

    // Payload state
    dlt_pkg::op_t           op_reg, op_next;
    logic                   has_req_reg, has_req_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [MW-1:0]          mac_reg, mac_next;
    logic [MW-1:0]          mask_reg, mask_next;
    logic [IPW-1:0]         req_ip_reg, req_ip_next;
    logic [CNT_W-1:0]       iss_reg, iss_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]       own_idx_reg, own_idx_next;
    logic [IPW-1:0]         own_pool_reg, own_pool_next;
    logic [IDX_W-1:0]       addr_idx_reg, addr_idx_next;
    logic [IPW-1:0]         addr_pool_reg, addr_pool_next;
    logic                   addr_alloc_reg, addr_alloc_next;
    logic [IDX_W-1:0]       spare_idx_reg, spare_idx_next;
    logic [IPW-1:0]         spare_pool_reg, spare_pool_next;
    logic [IDX_W-1:0]       claim_idx_reg, claim_idx_next;
    logic [IPW-1:0]         claim_pool_reg, claim_pool_next;
    logic [dlt_pkg::RKIND_W-1:0] out_kind_reg, out_kind_next;
    logic [IPW-1:0]         out_addr_reg, out_addr_next;
    logic [dlt_pkg::GENT_W-1:0]  out_entry_reg, out_entry_next;

    // Memory ports
    logic                   p_we;
    logic [IDX_W-1:0]       p_waddr;
    logic [IDX_W-1:0]       p_raddr;
    logic [IPW-1:0]         p_rdata;
    logic                   o_we;
    logic [IDX_W-1:0]       o_raddr;
    logic [MW-1:0]          o_wdata;
    logic [MW-1:0]          o_rdata;

    dlt_ram #(.WIDTH(IPW), .DEPTH(TABLE_DEPTH)) u_pool_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (c_addr),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    dlt_ram #(.WIDTH(MW), .DEPTH(TABLE_DEPTH)) u_owner_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (claim_idx_reg),
        .wdata (o_wdata),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    assign rsp_ch.valid           = out_valid_reg;
    assign rsp_ch.reply_kind      = out_kind_reg;
    assign rsp_ch.granted_address = out_addr_reg;
    assign rsp_ch.granted_entry   = out_entry_reg;

    always_comb
    begin
        logic             ent_valid;
        logic             ent_alloc;
        logic [MW-1:0]    old_owner;

        state_next       = state_reg;
        valid_next       = valid_reg;
        alloc_next       = alloc_reg;
        out_valid_next   = out_valid_reg && !rsp_ch.ready;
        rd_pend_next     = 1'b0;
        own_found_next   = own_found_reg;
        addr_found_next  = addr_found_reg;
        spare_found_next = spare_found_reg;
        spare_lock_next  = spare_lock_reg;
        op_next          = op_reg;
        has_req_next     = has_req_reg;
        cnt_next         = cnt_reg;
        mac_next         = mac_reg;
        mask_next        = mask_reg;
        req_ip_next      = req_ip_reg;
        iss_next         = iss_reg;
        rd_idx_next      = rd_idx_reg;
        own_idx_next     = own_idx_reg;
        own_pool_next    = own_pool_reg;
        addr_idx_next    = addr_idx_reg;
        addr_pool_next   = addr_pool_reg;
        addr_alloc_next  = addr_alloc_reg;
        spare_idx_next   = spare_idx_reg;
        spare_pool_next  = spare_pool_reg;
        claim_idx_next   = claim_idx_reg;
        claim_pool_next  = claim_pool_reg;
        out_kind_next    = out_kind_reg;
        out_addr_next    = out_addr_reg;
        out_entry_next   = out_entry_reg;
        cmd_pop          = 1'b0;
        p_we             = 1'b0;
        p_waddr          = IDX_W'(c_lidx);
        p_raddr          = iss_reg[IDX_W-1:0];
        o_we             = 1'b0;
        o_raddr          = iss_reg[IDX_W-1:0];
        ent_valid        = valid_reg[rd_idx_reg];
        ent_alloc        = alloc_reg[rd_idx_reg];
        old_owner        = valid_reg[claim_idx_reg] ? o_rdata : '0;
        o_wdata          = (old_owner & ~mask_reg) | (mac_reg & mask_reg);

        unique case (state_reg)
            dlt_pkg::BK_IDLE:
            begin
                if (cmd_valid && c_ctl.op == dlt_pkg::OP_LOAD)
                begin
                    p_we    = 1'b1;
                    cmd_pop = 1'b1;
                end
                else if (cmd_valid && !out_valid_reg)
                begin
                    cmd_pop          = 1'b1;
                    op_next          = c_ctl.op;
                    has_req_next     = c_ctl.has_req;
                    cnt_next         = c_cnt;
                    mac_next         = c_mac;
                    mask_next        = c_mask;
                    req_ip_next      = c_addr;
                    iss_next         = '0;
                    own_found_next   = 1'b0;
                    addr_found_next  = 1'b0;
                    spare_found_next = 1'b0;
                    spare_lock_next  = 1'b0;
                    state_next       = dlt_pkg::BK_SCAN;
                end
            end
            dlt_pkg::BK_SCAN:
            begin
                // Issue one entry read a cycle; evaluate it the cycle after
                if (iss_reg < cnt_reg)
                begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = iss_reg[IDX_W-1:0];
                    iss_next     = iss_reg + 1'b1;
                end
                else
                begin
                    state_next = dlt_pkg::BK_DECIDE;
                end
                if (rd_pend_reg)
                begin
                    if (!own_found_reg && ent_valid &&
                        (((o_rdata ^ mac_reg) & mask_reg) == '0))
                    begin
                        own_found_next = 1'b1;
                        own_idx_next   = rd_idx_reg;
                        own_pool_next  = p_rdata;
                    end
                    if (!addr_found_reg && p_rdata == req_ip_reg)
                    begin
                        addr_found_next = 1'b1;
                        addr_idx_next   = rd_idx_reg;
                        addr_pool_next  = p_rdata;
                        addr_alloc_next = ent_alloc;
                    end
                    if (!spare_lock_reg && (!ent_valid || !ent_alloc))
                    begin
                        spare_found_next = 1'b1;
                        spare_lock_next  = !ent_valid;
                        spare_idx_next   = rd_idx_reg;
                        spare_pool_next  = p_rdata;
                    end
                end
            end
            dlt_pkg::BK_DECIDE:
            begin
                state_next = dlt_pkg::BK_IDLE;
                unique case (op_reg)
                    dlt_pkg::OP_DISCOVER:
                    begin
                        if (own_found_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = dlt_pkg::REPLY_OFFER;
                            out_addr_next  = own_pool_reg;
                            out_entry_next = dlt_pkg::GENT_W'(own_idx_reg);
                        end
                        else if (has_req_reg && addr_found_reg && !addr_alloc_reg)
                        begin
                            claim_idx_next  = addr_idx_reg;
                            claim_pool_next = addr_pool_reg;
                            state_next      = dlt_pkg::BK_CLAIM_RD;
                        end
                        else if (spare_found_reg)
                        begin
                            claim_idx_next  = spare_idx_reg;
                            claim_pool_next = spare_pool_reg;
                            state_next      = dlt_pkg::BK_CLAIM_RD;
                        end
                    end
                    dlt_pkg::OP_REQUEST:
                    begin
                        out_valid_next = 1'b1;
                        if (own_found_reg)
                        begin
                            alloc_next[own_idx_reg] = 1'b1;
                            out_kind_next  = dlt_pkg::REPLY_ACK;
                            out_addr_next  = own_pool_reg;
                            out_entry_next = dlt_pkg::GENT_W'(own_idx_reg);
                        end
                        else if (has_req_reg && addr_found_reg && !addr_alloc_reg)
                        begin
                            alloc_next[addr_idx_reg] = 1'b1;
                            out_kind_next  = dlt_pkg::REPLY_ACK;
                            out_addr_next  = addr_pool_reg;
                            out_entry_next = dlt_pkg::GENT_W'(addr_idx_reg);
                        end
                        else
                        begin
                            out_kind_next  = dlt_pkg::REPLY_NAK;
                            out_addr_next  = '0;
                            out_entry_next = '0;
                        end
                    end
                    dlt_pkg::OP_RELEASE:
                    begin
                        if (own_found_reg)
                        begin
                            alloc_next[own_idx_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                        state_next = dlt_pkg::BK_IDLE;
                    end
                endcase
            end
            dlt_pkg::BK_CLAIM_RD:
            begin
                o_raddr    = claim_idx_reg;
                state_next = dlt_pkg::BK_CLAIM_WR;
            end
            dlt_pkg::BK_CLAIM_WR:
            begin
                // Merge the leading bytes into the owner, then mark the entry
                o_we                      = 1'b1;
                valid_next[claim_idx_reg] = 1'b1;
                alloc_next[claim_idx_reg] = 1'b0;
                out_valid_next            = 1'b1;
                out_kind_next             = dlt_pkg::REPLY_OFFER;
                out_addr_next             = claim_pool_reg;
                out_entry_next            = dlt_pkg::GENT_W'(claim_idx_reg);
                state_next                = dlt_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = dlt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dlt_pkg::BK_IDLE;
            valid_reg       <= '0;
            alloc_reg       <= '0;
            out_valid_reg   <= 1'b0;
            rd_pend_reg     <= 1'b0;
            own_found_reg   <= 1'b0;
            addr_found_reg  <= 1'b0;
            spare_found_reg <= 1'b0;
            spare_lock_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            alloc_reg       <= alloc_next;
            out_valid_reg   <= out_valid_next;
            rd_pend_reg     <= rd_pend_next;
            own_found_reg   <= own_found_next;
            addr_found_reg  <= addr_found_next;
            spare_found_reg <= spare_found_next;
            spare_lock_reg  <= spare_lock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        has_req_reg    <= has_req_next;
        cnt_reg        <= cnt_next;
        mac_reg        <= mac_next;
        mask_reg       <= mask_next;
        req_ip_reg     <= req_ip_next;
        iss_reg        <= iss_next;
        rd_idx_reg     <= rd_idx_next;
        own_idx_reg    <= own_idx_next;
        own_pool_reg   <= own_pool_next;
        addr_idx_reg   <= addr_idx_next;
        addr_pool_reg  <= addr_pool_next;
        addr_alloc_reg <= addr_alloc_next;
        spare_idx_reg  <= spare_idx_next;
        spare_pool_reg <= spare_pool_next;
        claim_idx_reg  <= claim_idx_next;
        claim_pool_reg <= claim_pool_next;
        out_kind_reg   <= out_kind_next;
        out_addr_reg   <= out_addr_next;
        out_entry_reg  <= out_entry_next;
    end

`ifndef SYNTHESIS
    a_pop_needs_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && c_ctl.op != dlt_pkg::OP_LOAD) |-> !out_valid_reg)
        else $error("table command started while a reply still waits");

    a_reply_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == dlt_pkg::BK_DECIDE || $past(state_reg) == dlt_pkg::BK_CLAIM_WR))
        else $error("reply raised outside the decide or claim step");

    a_nak_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == dlt_pkg::REPLY_NAK) |->
            (out_addr_reg == '0 && out_entry_reg == '0))
        else $error("nak carries an address or entry");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (CNT_W'(rd_idx_reg) < cnt_reg))
        else $error("scan read beyond the entries in use");

    a_claim_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dlt_pkg::BK_CLAIM_WR) |=>
            (valid_reg[$past(claim_idx_reg)] && !alloc_reg[$past(claim_idx_reg)]))
        else $error("claimed entry not marked valid and free");
`endif

endmodule

`default_nettype wire

/* design/dhcp_lease_table.sv */
`default_nettype none

// DHCP lease table. Client messages arrive already parsed on req_ch; offers,
// acks and naks leave on rsp_ch. The user must write server_address (index 0)
// and entry_count (index 1) on cfg_ch only while the block is idle; the block
// does not enforce this. The front accepts a message whenever the queue has
// room, drops declines, informs, unknown kinds, out-of-range loads, requests
// and releases addressed to another server, and queues the rest in a two-deep
// command queue. The back works on one command at a time: a load writes the
// pool address memory; a discover, request or release scans all of the
// n = min(entry_count, TABLE_DEPTH) entries once, one entry per cycle through
// the single read port of each table memory, running the owner, requested-
// address and spare searches side by side. A discover claiming a new entry
// then does an owner read-modify-write. A reply sits in an output register;
// the back starts the next search only once that register is free, while the
// front keeps filling the queue. No clearing pass is needed after reset.
module dhcp_lease_table #(
    parameter int TABLE_DEPTH = 8,
    parameter int MAC_BYTES   = 6
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dlt_req_if.sink     req_ch,
    dlt_rsp_if.source   rsp_ch,
    dlt_cfg_if.sink     cfg_ch
);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MW    = 8 * MAC_BYTES;
    localparam int CMD_W = $bits(dlt_pkg::cmd_ctl_t) + CNT_W + MW + MAC_BYTES
                           + dlt_pkg::IP_W + dlt_pkg::LIDX_W;
    localparam int QUEUE_DEPTH = 2;

    // Command queue between the front and the back
    logic             q_push;
    logic [CMD_W-1:0] q_push_data;
    logic             q_full;
    logic             q_pop;
    logic [CMD_W-1:0] q_pop_data;
    logic             q_not_empty;

    // Classify and filter messages; hold the configuration registers
    dlt_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAC_BYTES   (MAC_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch),
        .cfg_ch    (cfg_ch),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full)
    );

    dlt_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    // Search the table, update marks and owners, and drive the reply
    dlt_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAC_BYTES   (MAC_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd_data  (q_pop_data),
        .cmd_pop   (q_pop),
        .rsp_ch    (rsp_ch)
    );

endmodule

`default_nettype wire
